// ===== hdl/assert_macros.svh =====
// assertion macros shared by the governor rtl
// no dependencies; expects a clock i_clk and an active low reset i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("governor assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("governor assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("governor assertion failed");

`endif

// ===== hdl/frqlg_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the frame rate quality level governor
// no dependencies
package frqlg_pkg;

    localparam int NUM_LEVELS_DEFAULT = 8;
    localparam int TBL_MAX_ENTRIES    = 8;   // entry index field is three bits

    localparam int TIME_W  = 32;
    localparam int FPS_W   = 16;
    localparam int EVAL_W  = 16;
    localparam int IDX_W   = 3;
    localparam int QLVL_W  = 3;
    localparam int LIU_W   = 4;
    localparam int CFG_W   = 4;   // widest register
    localparam int CFG_IDX_W = 1;

    localparam logic [TIME_W-1:0] WINDOW_MS       = 32'd1000;
    localparam logic [FPS_W-1:0]  FPS_AT_RESET    = 16'd100;
    localparam logic [FPS_W-1:0]  FRAME_COUNT_MAX = 16'hFFFF;

    // x / 5 as (x * DIV5_MUL) >> DIV5_SHIFT, exact for x below 2^19
    localparam int SUM_W = 19;
    localparam logic [SUM_W-1:0] DIV5_MUL   = 19'd419431;
    localparam int               DIV5_SHIFT = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_IN_USE = 1'b1;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_LOAD  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_DOWN = 2'd1,
        STEP_UP   = 2'd2
    } t_step;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [FPS_W-1:0]  high_fps;
        logic [FPS_W-1:0]  low_fps;
        logic [EVAL_W-1:0] eval_ms;
    } t_tbl_wr;

endpackage

// ===== hdl/frqlg_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces of the governor: item in, result out
// depends on frqlg_pkg
interface frqlg_in_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [frqlg_pkg::TIME_W-1:0]       time_ms;
    logic [frqlg_pkg::IDX_W-1:0]        entry_index;
    logic [frqlg_pkg::FPS_W-1:0]        entry_high_fps;
    logic [frqlg_pkg::FPS_W-1:0]        entry_low_fps;
    logic [frqlg_pkg::EVAL_W-1:0]       entry_eval_ms;

    modport source (
        output valid, operation, time_ms, entry_index,
               entry_high_fps, entry_low_fps, entry_eval_ms,
        input  ready
    );
    modport sink (
        input  valid, operation, time_ms, entry_index,
               entry_high_fps, entry_low_fps, entry_eval_ms,
        output ready
    );
endinterface

interface frqlg_out_if;
    logic                               valid;
    logic                               ready;
    logic [frqlg_pkg::QLVL_W-1:0]       quality_level;
    logic [frqlg_pkg::FPS_W-1:0]        measured_fps;
    logic [frqlg_pkg::FPS_W-1:0]        smoothed_fps;
    logic [1:0]                         level_step;
    logic                               state_reinit;

    modport source (
        output valid, quality_level, measured_fps, smoothed_fps,
               level_step, state_reinit,
        input  ready
    );
    modport sink (
        input  valid, quality_level, measured_fps, smoothed_fps,
               level_step, state_reinit,
        output ready
    );
endinterface

// ===== hdl/frame_rate_quality_level_governor_top.sv =====
`timescale 1ns / 1ps
// frame rate quality level governor, top level
// depends on frqlg_pkg, frqlg_if, frqlg_level_table, assert_macros.svh
//
//  channel     dir  content                                     transfer when
//  i_frame     in   operation, time_ms, table entry fields      valid && ready
//  o_status    out  level, measured/smoothed rate, step, reinit valid && ready
//  i_cfg_*     in   auto_enable (index 0), levels_in_use (1)    i_cfg_we
//
//  one item per cycle sustained while o_status.ready holds; an item passes the input
//  register, then the state and result register, which are written together
//  the whole update is combinational from the input register: window count, /5 smoothing
//  multiply, threshold lookup, level step and evaluation end add
//  synchronous active low reset clears control state and the governor state;
//  the level table is undefined until loaded
//  a stalled result holds the input register, which then holds i_frame.ready low
module frame_rate_quality_level_governor_top #(
    parameter int NUM_LEVELS = frqlg_pkg::NUM_LEVELS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [frqlg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [frqlg_pkg::CFG_W-1:0]       i_cfg_wdata,
    frqlg_in_if.sink                          i_frame,
    frqlg_out_if.source                       o_status
);
    // levels above fifteen are unreachable through the four bit level count
    localparam int LVL_CAP = (NUM_LEVELS < 16) ? NUM_LEVELS : 16;
    localparam int LVL_W   = $clog2(LVL_CAP);
    localparam int TBL_D   = (NUM_LEVELS < frqlg_pkg::TBL_MAX_ENTRIES) ?
                             NUM_LEVELS : frqlg_pkg::TBL_MAX_ENTRIES;
    localparam int TBL_AW  = $clog2(TBL_D);
    localparam int LIM_W   = 5;

    // configuration registers
    logic                           r_auto;
    logic [frqlg_pkg::LIU_W-1:0]    r_levels;

    // input register
    logic                              r_in_valid;
    frqlg_pkg::t_op                    r_in_op;
    logic [frqlg_pkg::TIME_W-1:0]      r_in_time;
    logic [frqlg_pkg::IDX_W-1:0]       r_in_idx;
    logic [frqlg_pkg::FPS_W-1:0]       r_in_high;
    logic [frqlg_pkg::FPS_W-1:0]       r_in_low;
    logic [frqlg_pkg::EVAL_W-1:0]      r_in_eval;

    // governor state
    logic [frqlg_pkg::FPS_W-1:0]       r_frames,   n_frames;
    logic [frqlg_pkg::TIME_W-1:0]      r_start,    n_start;
    logic [frqlg_pkg::FPS_W-1:0]       r_last,     n_last;
    logic [frqlg_pkg::FPS_W-1:0]       r_filt,     n_filt;
    logic [frqlg_pkg::TIME_W-1:0]      r_eval_end, n_eval_end;
    logic [LVL_W-1:0]                  r_level,    n_level;

    // result register
    logic                              r_out_valid;
    logic [frqlg_pkg::QLVL_W-1:0]      r_out_level;
    logic [frqlg_pkg::FPS_W-1:0]       r_out_meas;
    logic [frqlg_pkg::FPS_W-1:0]       r_out_filt;
    frqlg_pkg::t_step                  r_out_step, n_step;
    logic                              r_out_reinit, n_reinit;

    logic                              adv;
    frqlg_pkg::t_tbl_wr                tbl_wr;
    logic [frqlg_pkg::FPS_W-1:0]       tbl_high;
    logic [frqlg_pkg::FPS_W-1:0]       tbl_low;
    logic [frqlg_pkg::EVAL_W-1:0]      tbl_eval;

    logic [frqlg_pkg::FPS_W-1:0]       cnt_inc;
    logic                              win_close;
    logic [frqlg_pkg::FPS_W-1:0]       win_last;
    logic                              decide;
    logic [LIM_W-1:0]                  limit;
    logic [LIM_W-1:0]                  lvl_ext;
    logic [frqlg_pkg::SUM_W-1:0]       filt_sum;
    logic [2*frqlg_pkg::SUM_W-1:0]     filt_prod;
    logic [frqlg_pkg::TIME_W:0]        end_sum;

    // advance a held item when the result register is free or being emptied
    assign adv           = r_in_valid && (!r_out_valid || o_status.ready);
    assign i_frame.ready = !r_in_valid || adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto   <= 1'b1;
            r_levels <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                frqlg_pkg::CFG_AUTO_ENABLE:   r_auto   <= i_cfg_wdata[0];
                frqlg_pkg::CFG_LEVELS_IN_USE: r_levels <= i_cfg_wdata[frqlg_pkg::LIU_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.valid && i_frame.ready) begin
            r_in_op   <= frqlg_pkg::t_op'(i_frame.operation);
            r_in_time <= i_frame.time_ms;
            r_in_idx  <= i_frame.entry_index;
            r_in_high <= i_frame.entry_high_fps;
            r_in_low  <= i_frame.entry_low_fps;
            r_in_eval <= i_frame.entry_eval_ms;
        end
    end

    frqlg_level_table #(
        .DEPTH (TBL_D)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr        (tbl_wr),
        .i_thr_addr  (r_level[TBL_AW-1:0]),
        .o_high_fps  (tbl_high),
        .o_low_fps   (tbl_low),
        .i_eval_addr (n_level[TBL_AW-1:0]),
        .o_eval_ms   (tbl_eval)
    );

    // number of valid levels, capped by NUM_LEVELS limited to sixteen
    assign limit   = (32'(r_levels) < 32'(LVL_CAP)) ? LIM_W'(r_levels) : LIM_W'(LVL_CAP);
    assign lvl_ext = LIM_W'(r_level);

    // frame count saturates
    assign cnt_inc   = (r_frames != frqlg_pkg::FRAME_COUNT_MAX) ? r_frames + 1'b1 : r_frames;
    // window closes strictly after one second, no wrap handling
    assign win_close = {1'b0, r_in_time} >
                       ({1'b0, r_start} + (frqlg_pkg::TIME_W+1)'(frqlg_pkg::WINDOW_MS));
    // measured rate once this frame is counted
    assign win_last  = win_close ? cnt_inc : r_last;

    // smoothing (3*old + 2*measured) / 5 with the measured value after this frame
    assign filt_sum  = frqlg_pkg::SUM_W'({r_filt, 1'b0}) + frqlg_pkg::SUM_W'(r_filt)
                     + frqlg_pkg::SUM_W'({win_last, 1'b0});
    assign filt_prod = filt_sum * frqlg_pkg::DIV5_MUL;

    // next evaluation end, saturating, period taken from the level chosen by this update
    assign end_sum    = {1'b0, r_in_time} + (frqlg_pkg::TIME_W+1)'(tbl_eval);
    assign n_eval_end = n_reinit ? '0 :
                        !decide  ? r_eval_end :
                        end_sum[frqlg_pkg::TIME_W] ? '1 : end_sum[frqlg_pkg::TIME_W-1:0];

    always_comb begin
        n_frames   = r_frames;
        n_start    = r_start;
        n_last     = r_last;
        n_filt     = r_filt;
        n_level    = r_level;
        n_step     = frqlg_pkg::STEP_NONE;
        n_reinit   = 1'b0;
        decide     = 1'b0;
        tbl_wr     = '{en: 1'b0, idx: r_in_idx, high_fps: r_in_high,
                       low_fps: r_in_low, eval_ms: r_in_eval};

        if (r_in_op == frqlg_pkg::OP_LOAD) begin
            tbl_wr.en = adv;
        end else begin
            if (win_close) begin
                n_start  = r_in_time;
                n_last   = cnt_inc;
                n_frames = '0;
            end else begin
                n_frames = cnt_inc;
            end

            if (r_auto) begin
                if (lvl_ext >= limit) begin
                    // invalid level: everything back to its reset value
                    n_frames   = '0;
                    n_start    = '0;
                    n_last     = frqlg_pkg::FPS_AT_RESET;
                    n_filt     = frqlg_pkg::FPS_AT_RESET;
                    n_level    = '0;
                    n_reinit   = 1'b1;
                end else if (r_in_time < r_eval_end) begin
                    n_filt = filt_prod[frqlg_pkg::DIV5_SHIFT +: frqlg_pkg::FPS_W];
                end else begin
                    decide = 1'b1;
                    if (r_filt > tbl_high) begin
                        if (r_level != '0) begin
                            n_level = r_level - 1'b1;
                            n_step  = frqlg_pkg::STEP_DOWN;
                        end
                    end else if (r_filt < tbl_low) begin
                        if ((lvl_ext + 1'b1) < limit) begin
                            n_level = r_level + 1'b1;
                            n_step  = frqlg_pkg::STEP_UP;
                        end
                    end
                end
            end
        end
    end

    // governor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames   <= '0;
            r_start    <= '0;
            r_last     <= frqlg_pkg::FPS_AT_RESET;
            r_filt     <= frqlg_pkg::FPS_AT_RESET;
            r_eval_end <= '0;
            r_level    <= '0;
        end else if (adv) begin
            r_frames   <= n_frames;
            r_start    <= n_start;
            r_last     <= n_last;
            r_filt     <= n_filt;
            r_eval_end <= n_eval_end;
            r_level    <= n_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_status.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_level  <= frqlg_pkg::QLVL_W'(n_level);
            r_out_meas   <= n_last;
            r_out_filt   <= n_filt;
            r_out_step   <= n_step;
            r_out_reinit <= n_reinit;
        end
    end

    assign o_status.valid         = r_out_valid;
    assign o_status.quality_level = r_out_level;
    assign o_status.measured_fps  = r_out_meas;
    assign o_status.smoothed_fps  = r_out_filt;
    assign o_status.level_step    = r_out_step;
    assign o_status.state_reinit  = r_out_reinit;

    // checks
    `include "assert_macros.svh"

    // a forced reinit always reports level zero with no step
    `ASSERT_SAME(a_reinit_clean, r_out_valid && r_out_reinit, (r_out_level == '0) && (r_out_step == frqlg_pkg::STEP_NONE))
    // a reported step down really lowered the level by one
    `ASSERT_NEXT(a_step_down, adv && (n_step == frqlg_pkg::STEP_DOWN), r_level == LVL_W'($past(r_level) - 1'b1))
    // a reported step up really raised the level by one
    `ASSERT_NEXT(a_step_up, adv && (n_step == frqlg_pkg::STEP_UP), r_level == LVL_W'($past(r_level) + 1'b1))
    // a held result with a full input register blocks new transfers
    `ASSERT_SAME(a_stall_blocks, r_in_valid && r_out_valid && !o_status.ready, !i_frame.ready)

endmodule

// ===== hdl/frqlg_level_table.sv =====
`timescale 1ns / 1ps
// per-level table: thresholds and evaluation periods in two register arrays
// depends on frqlg_pkg
module frqlg_level_table #(
    parameter int DEPTH = frqlg_pkg::TBL_MAX_ENTRIES
) (
    input  logic                          i_clk,
    input  frqlg_pkg::t_tbl_wr            i_wr,
    input  logic [$clog2(DEPTH)-1:0]      i_thr_addr,
    output logic [frqlg_pkg::FPS_W-1:0]   o_high_fps,
    output logic [frqlg_pkg::FPS_W-1:0]   o_low_fps,
    input  logic [$clog2(DEPTH)-1:0]      i_eval_addr,
    output logic [frqlg_pkg::EVAL_W-1:0]  o_eval_ms
);
    localparam int AW = $clog2(DEPTH);

    logic [2*frqlg_pkg::FPS_W-1:0] r_thr  [DEPTH];
    logic [frqlg_pkg::EVAL_W-1:0]  r_eval [DEPTH];
    logic                          wr_hit;

    // entries beyond the depth are dropped
    assign wr_hit = i_wr.en && (32'(i_wr.idx) < 32'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_thr[i_wr.idx[AW-1:0]]  <= {i_wr.high_fps, i_wr.low_fps};
            r_eval[i_wr.idx[AW-1:0]] <= i_wr.eval_ms;
        end
    end

    assign o_high_fps = r_thr[i_thr_addr][2*frqlg_pkg::FPS_W-1:frqlg_pkg::FPS_W];
    assign o_low_fps  = r_thr[i_thr_addr][frqlg_pkg::FPS_W-1:0];
    assign o_eval_ms  = r_eval[i_eval_addr];

endmodule
